// File: src/itra_pkg.sv
`timescale 1ns / 1ps
// Package for the integer to radix ASCII converter.
// Holds the item types, the controller interface structs, the state encoding
// and the digit to character function. It depends on nothing else.
package itra_pkg;

    // Radix limits and the one radix that reads the value as signed.
    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] DEC_RADIX = 6'd10;

    // ASCII codes used to build the text.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ALPHA = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Quotient bits that the divider resolves in one clock cycle.
    localparam int STEPS_PER_CYCLE = 8;

    // One input item: the number and the radix of its text.
    typedef struct packed {
        logic signed [31:0] number;
        logic [5:0]         base;
    } value_item_t;

    // One result item: a single character of the text.
    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } text_item_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_FETCH,
        ST_PUT
    } itra_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic div_step;
        logic load_sign;
        logic rd_issue;
        logic load_digit;
    } itra_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_done;
        logic negative;
        logic ptr_zero;
        logic out_free;
    } itra_status_t;

    // Map a digit value below 36 to its character.
    function automatic logic [7:0] digit_char(input logic [5:0] digit);
        logic [7:0] code;
        if (digit < 6'd10)
        begin
            code = CHAR_ZERO + {2'b00, digit};
        end
        else
        begin
            code = CHAR_ALPHA + {2'b00, digit} - 8'd10;
        end
        return code;
    endfunction

endpackage

// File: src/itra_ctrl.sv
`timescale 1ns / 1ps
// Controller for the integer to radix ASCII converter.
// Sequences conversion, sign output and reversed digit output; uses itra_pkg.
module itra_ctrl
    import itra_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         value_valid,
    output logic         value_ready,
    input  itra_status_t status,
    output itra_cmd_t    cmd
);

    itra_state_t state_reg;
    itra_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        value_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                value_ready = 1'b1;
                if (value_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.conv_done)
                begin
                    state_next = status.negative ? ST_SIGN : ST_FETCH;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.load_sign = 1'b1;
                    state_next    = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_PUT;
            end
            ST_PUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_digit = 1'b1;
                    state_next     = status.ptr_zero ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/itra_dpath.sv
`timescale 1ns / 1ps
// Datapath for the integer to radix ASCII converter: radix divider, digit
// store and output register. Driven by itra_ctrl; uses itra_pkg.
module itra_dpath
    import itra_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  value_item_t  value,
    input  logic         text_ready,
    output logic         text_valid,
    output text_item_t   text,
    input  itra_cmd_t    cmd,
    output itra_status_t status
);

    localparam int AW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic [5:0]            radix_sat;
    logic                  neg_in;

    logic [5:0]            radix_reg;
    logic                  neg_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [5:0]            rem_reg;
    logic [CW-1:0]         bits_reg;
    logic [CW-1:0]         ndig_reg;
    logic [AW-1:0]         ptr_reg;
    logic [7:0]            rdata_reg;
    text_item_t            out_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic [VALUE_BITS-1:0] div_val;
    logic [5:0]            div_rem;
    logic [6:0]            div_trial;
    logic                  div_qbit;
    logic                  digit_end;

    logic [7:0]            digit_mem [VALUE_BITS];

    // Input decode: size the value, clamp the radix, take the magnitude.
    always_comb
    begin
        raw = VALUE_BITS'(value.number);
        if (value.base < RADIX_MIN)
        begin
            radix_sat = RADIX_MIN;
        end
        else if (value.base > RADIX_MAX)
        begin
            radix_sat = RADIX_MAX;
        end
        else
        begin
            radix_sat = value.base;
        end
        neg_in = (value.base == DEC_RADIX) && raw[VALUE_BITS-1];
        mag    = neg_in ? VALUE_BITS'(~raw + VALUE_BITS'(1)) : raw;
    end

    // Restoring division by the radix, a fixed number of quotient bits a cycle.
    always_comb
    begin
        div_val   = val_reg;
        div_rem   = rem_reg;
        div_trial = '0;
        div_qbit  = 1'b0;
        for (int i = 0; i < STEPS_PER_CYCLE; i++)
        begin
            if (CW'(i) < bits_reg)
            begin
                div_trial = {div_rem, div_val[VALUE_BITS-1]};
                if (div_trial >= {1'b0, radix_reg})
                begin
                    div_rem  = 6'(div_trial - {1'b0, radix_reg});
                    div_qbit = 1'b1;
                end
                else
                begin
                    div_rem  = div_trial[5:0];
                    div_qbit = 1'b0;
                end
                div_val = {div_val[VALUE_BITS-2:0], div_qbit};
            end
        end
        digit_end = (bits_reg <= CW'(STEPS_PER_CYCLE));
    end

    // Conversion registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            radix_reg <= radix_sat;
            neg_reg   <= neg_in;
            val_reg   <= mag;
            rem_reg   <= '0;
            bits_reg  <= CW'(VALUE_BITS);
            ndig_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            val_reg <= div_val;
            if (digit_end)
            begin
                rem_reg  <= '0;
                bits_reg <= CW'(VALUE_BITS);
                ndig_reg <= ndig_reg + CW'(1);
            end
            else
            begin
                rem_reg  <= div_rem;
                bits_reg <= bits_reg - CW'(STEPS_PER_CYCLE);
            end
        end
    end

    // Read pointer walks the stored digits from the most significant down.
    always_ff @(posedge clk)
    begin
        if (cmd.div_step && digit_end)
        begin
            ptr_reg <= ndig_reg[AW-1:0];
        end
        else if (cmd.load_digit)
        begin
            ptr_reg <= ptr_reg - AW'(1);
        end
    end

    // Digit store, least significant digit first, with a registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.div_step && digit_end)
        begin
            digit_mem[ndig_reg[AW-1:0]] <= digit_char(div_rem);
        end
        if (cmd.rd_issue)
        begin
            rdata_reg <= digit_mem[ptr_reg];
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_sign)
        begin
            out_reg.out_char  <= CHAR_MINUS;
            out_reg.last_char <= 1'b0;
        end
        else if (cmd.load_digit)
        begin
            out_reg.out_char  <= rdata_reg;
            out_reg.last_char <= (ptr_reg == '0);
        end
    end

    // Output valid flag.
    always_comb
    begin
        if (cmd.load_sign || cmd.load_digit)
        begin
            out_valid_next = 1'b1;
        end
        else if (text_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Status toward the controller and output ports.
    always_comb
    begin
        status.conv_done = digit_end && (div_val == '0);
        status.negative  = neg_reg;
        status.ptr_zero  = (ptr_reg == '0);
        status.out_free  = !out_valid_reg || text_ready;
    end

    assign text_valid = out_valid_reg;
    assign text       = out_reg;

endmodule

// File: src/integer_to_radix_ascii.sv
`timescale 1ns / 1ps
// Top level of the integer to radix ASCII converter.
// Joins itra_ctrl and itra_dpath; uses itra_pkg.
//
//  Channel  Handshake                 Payload        Item
//  value    value_valid/value_ready   value_item_t   number and radix
//  text     text_valid/text_ready     text_item_t    one character of the text
//
// One item at a time. Each digit is worked out in the radix divider, which
// resolves eight quotient bits a cycle; each character then takes a digit store
// read and an output load, and a minus sign, if any, comes before the digits.
// Reset clears the controller and the output valid flag; the digit store has none.
// A stalled text channel holds the block in its output states; the last
// character waits in the output register while the next item is accepted.
module integer_to_radix_ascii
    import itra_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        value_valid,
    output logic        value_ready,
    input  value_item_t value,
    output logic        text_valid,
    input  logic        text_ready,
    output text_item_t  text
);

    itra_cmd_t    cmd;
    itra_status_t status;

    itra_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .status      (status),
        .cmd         (cmd)
    );

    itra_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .text_ready (text_ready),
        .text_valid (text_valid),
        .text       (text),
        .cmd        (cmd),
        .status     (status)
    );

    // The block takes no new item right after accepting one.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (value_valid && value_ready) |=> !value_ready
    ) else $error("new item taken while conversion in progress");

    // A character is loaded only when the output register is free.
    a_load_when_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.load_sign || cmd.load_digit) |-> (!text_valid || text_ready)
    ) else $error("output register overwritten");

    // Loading the final character returns the block to accepting items.
    a_last_then_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.load_digit && status.ptr_zero) |=> (value_ready && text.last_char)
    ) else $error("final character did not end the item");

endmodule
